>>> design/tsvn_pkg.sv
// ----------------------------------------------------------------------------
// tsvn_pkg
// shared constants, character codes and types of the text stream visualizer
// ----------------------------------------------------------------------------
`default_nettype none

package tsvn_pkg;

  // line counter and result sizing
  localparam int NUMBER_DIGITS = 10;
  localparam int MIN_NUM_WIDTH = 6;
  localparam int MAX_RESULTS   = 15;
  localparam int TAIL_MAX      = 4;
  localparam int QUEUE_DEPTH   = 2;

  localparam int SIG_W     = $clog2(NUMBER_DIGITS + 1);
  localparam int DIG_IDX_W = $clog2(NUMBER_DIGITS);
  localparam int POS_W     = $clog2(MAX_RESULTS);
  localparam int LEN_W     = $clog2(NUMBER_DIGITS + TAIL_MAX + 2);
  localparam int TLEN_W    = $clog2(TAIL_MAX + 1);
  localparam int TIDX_W    = $clog2(TAIL_MAX);
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_ALL       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK  = 3'd5;

  // character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_M      = 8'h4d;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [6:0] LOW_DEL   = 7'h7f;
  localparam logic [6:0] LOW_SPACE = 7'h20;
  localparam logic [7:0] CARET_OFS = 8'd64;
  localparam logic [3:0] BCD_NINE  = 4'd9;

  typedef struct packed {
    logic show_nonprinting;
    logic show_tabs;
    logic squeeze_blank;
    logic number_all;
    logic show_ends;
    logic number_nonblank;
  } cfg_t;

  typedef logic [NUMBER_DIGITS-1:0][3:0] bcd_t;

  // one classified transaction: optional number prefix, then the tail bytes
  typedef struct packed {
    logic                         num_en;
    bcd_t                         digits;
    logic [SIG_W-1:0]             sig;
    logic [SIG_W-1:0]             width;
    logic [TAIL_MAX-1:0][7:0]     tail;
    logic [POS_W-1:0]             len_m1;
  } job_t;

endpackage

`default_nettype wire

>>> design/text_stream_visualizer_numberer.sv
// ----------------------------------------------------------------------------
// text_stream_visualizer_numberer
// byte stream filter: line numbering, blank squeezing, visible control bytes
// ----------------------------------------------------------------------------
// One raw text byte is taken per input transaction, with file_start marking
// the first byte of a new file. Each input yields zero to fifteen output
// transactions, the last of which has last_of_run set; a squeezed repeated
// empty line yields none. A byte that maps to one output byte is taken every
// cycle unless stalled; an input that expands to n bytes (number prefix, '$',
// caret or M-notation) gives n output transactions, one byte per cycle from
// the back sequencer unless out_ready stalls it; a two-entry job queue lets
// the front keep accepting while a run drains. Configuration writes take
// effect at once; the user must make them while the block is idle; the
// block does not check it. The line counter spans files, stops at all nines.
`default_nettype none

module text_stream_visualizer_numberer (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // input bytes
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       data_byte,
  input  wire logic                             file_start,
  // output bytes
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [7:0]                            char_out,
  output logic                                  last_of_run,
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tsvn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic                             cfg_data
);

  tsvn_pkg::cfg_t cfg;
  tsvn_pkg::job_t push_job;
  tsvn_pkg::job_t head;
  logic push;
  logic pop;
  logic q_valid;
  logic q_full;

  // configuration is always taken; unknown indexes are ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tsvn_pkg::REG_SHOW_NONPRINTING: cfg.show_nonprinting <= cfg_data;
        tsvn_pkg::REG_SHOW_TABS:        cfg.show_tabs        <= cfg_data;
        tsvn_pkg::REG_SQUEEZE_BLANK:    cfg.squeeze_blank    <= cfg_data;
        tsvn_pkg::REG_NUMBER_ALL:       cfg.number_all       <= cfg_data;
        tsvn_pkg::REG_SHOW_ENDS:        cfg.show_ends        <= cfg_data;
        tsvn_pkg::REG_NUMBER_NONBLANK:  cfg.number_nonblank  <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: line marks, counter snapshot, tail bytes
  tsvn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .file_start (file_start),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  // decoupling queue
  tsvn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .head     (head)
  );

  // back: one output byte per cycle into the output register while not stalled
  tsvn_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .job         (head),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .char_out    (char_out),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

>>> design/tsvn_front.sv
// ----------------------------------------------------------------------------
// tsvn_front
// accepts input bytes, tracks line state and the line counter, builds jobs
// ----------------------------------------------------------------------------
`default_nettype none

module tsvn_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tsvn_pkg::cfg_t  cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      data_byte,
  input  wire logic            file_start,
  input  wire logic            q_full,
  output logic                 push,
  output tsvn_pkg::job_t       push_job
);

  tsvn_pkg::bcd_t digits;
  tsvn_pkg::bcd_t digits_next;
  tsvn_pkg::bcd_t digits_inc;
  logic at_line_start;
  logic prev_blank;

  logic at_ls_eff;
  logic prev_eff;
  logic is_nl;
  logic drop;
  logic num_en;
  logic accept;
  logic carry;
  logic [tsvn_pkg::SIG_W-1:0]  sig;
  logic [tsvn_pkg::SIG_W-1:0]  width;
  logic [tsvn_pkg::TAIL_MAX-1:0][7:0] tail;
  logic [tsvn_pkg::TLEN_W-1:0] tail_len;
  logic [tsvn_pkg::LEN_W-1:0]  nlen;
  logic [tsvn_pkg::LEN_W-1:0]  total;
  logic [6:0] lo;
  logic [7:0] lv0;
  logic [7:0] lv1;
  logic       lv_two;

  always_comb begin
    at_ls_eff = file_start | at_line_start;
    prev_eff  = ~file_start & prev_blank;
    is_nl     = (data_byte == tsvn_pkg::CH_NL);
    drop      = is_nl & at_ls_eff & prev_eff & cfg.squeeze_blank;
    if (is_nl) begin
      num_en = at_ls_eff & cfg.number_all & ~cfg.number_nonblank;
    end else begin
      num_en = at_ls_eff & (cfg.number_all | cfg.number_nonblank);
    end

    // significant digits and field width
    sig = tsvn_pkg::SIG_W'(1);
    for (int i = 0; i < tsvn_pkg::NUMBER_DIGITS; i++) begin
      if (digits[i] != 4'd0) sig = tsvn_pkg::SIG_W'(i + 1);
    end
    width = (sig > tsvn_pkg::SIG_W'(tsvn_pkg::MIN_NUM_WIDTH)) ? sig :
            tsvn_pkg::SIG_W'(tsvn_pkg::MIN_NUM_WIDTH);

    // bcd increment, saturating at all nines
    carry = 1'b1;
    for (int i = 0; i < tsvn_pkg::NUMBER_DIGITS; i++) begin
      if (carry) begin
        digits_inc[i] = (digits[i] == tsvn_pkg::BCD_NINE) ? 4'd0 : digits[i] + 4'd1;
      end else begin
        digits_inc[i] = digits[i];
      end
      carry = carry & (digits[i] == tsvn_pkg::BCD_NINE);
    end
    digits_next = carry ? digits : digits_inc;

    // caret form of the low seven bits
    lo = data_byte[6:0];
    if (lo < tsvn_pkg::LOW_SPACE) begin
      lv0    = tsvn_pkg::CH_CARET;
      lv1    = {1'b0, lo} + tsvn_pkg::CARET_OFS;
      lv_two = 1'b1;
    end else if (lo == tsvn_pkg::LOW_DEL) begin
      lv0    = tsvn_pkg::CH_CARET;
      lv1    = tsvn_pkg::CH_QMARK;
      lv_two = 1'b1;
    end else begin
      lv0    = {1'b0, lo};
      lv1    = tsvn_pkg::CH_CARET;
      lv_two = 1'b0;
    end

    // bytes that follow the number prefix
    tail = '0;
    if (is_nl) begin
      if (cfg.show_ends) begin
        tail[0]  = tsvn_pkg::CH_DOLLAR;
        tail[1]  = tsvn_pkg::CH_NL;
        tail_len = tsvn_pkg::TLEN_W'(2);
      end else begin
        tail[0]  = tsvn_pkg::CH_NL;
        tail_len = tsvn_pkg::TLEN_W'(1);
      end
    end else if (data_byte == tsvn_pkg::CH_TAB && cfg.show_tabs) begin
      tail[0]  = tsvn_pkg::CH_CARET;
      tail[1]  = tsvn_pkg::CH_I;
      tail_len = tsvn_pkg::TLEN_W'(2);
    end else if (!cfg.show_nonprinting || data_byte == tsvn_pkg::CH_TAB) begin
      tail[0]  = data_byte;
      tail_len = tsvn_pkg::TLEN_W'(1);
    end else if (data_byte[7]) begin
      tail[0]  = tsvn_pkg::CH_M;
      tail[1]  = tsvn_pkg::CH_DASH;
      tail[2]  = lv0;
      tail[3]  = lv1;
      tail_len = lv_two ? tsvn_pkg::TLEN_W'(4) : tsvn_pkg::TLEN_W'(3);
    end else begin
      tail[0]  = lv0;
      tail[1]  = lv1;
      tail_len = lv_two ? tsvn_pkg::TLEN_W'(2) : tsvn_pkg::TLEN_W'(1);
    end

    // result count, clipped to the run limit
    nlen  = num_en ? tsvn_pkg::LEN_W'(width) + tsvn_pkg::LEN_W'(1) : '0;
    total = nlen + tsvn_pkg::LEN_W'(tail_len);

    push_job.num_en = num_en;
    push_job.digits = digits;
    push_job.sig    = sig;
    push_job.width  = width;
    push_job.tail   = tail;
    if (total > tsvn_pkg::LEN_W'(tsvn_pkg::MAX_RESULTS)) begin
      push_job.len_m1 = tsvn_pkg::POS_W'(tsvn_pkg::MAX_RESULTS - 1);
    end else begin
      push_job.len_m1 = tsvn_pkg::POS_W'(total - tsvn_pkg::LEN_W'(1));
    end
  end

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;
  assign push     = accept & ~drop;

  // a squeezed newline leaves every mark as it was
  always_ff @(posedge clk) begin
    if (rst) begin
      digits        <= tsvn_pkg::bcd_t'(1);
      at_line_start <= 1'b1;
      prev_blank    <= 1'b0;
    end else if (accept && !drop) begin
      at_line_start <= is_nl;
      prev_blank    <= is_nl & at_ls_eff;
      if (num_en) digits <= digits_next;
    end
  end

endmodule

`default_nettype wire

>>> design/tsvn_queue.sv
// ----------------------------------------------------------------------------
// tsvn_queue
// short job queue between the classifying front and the emitting back
// ----------------------------------------------------------------------------
`default_nettype none

module tsvn_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire tsvn_pkg::job_t  push_job,
  input  wire logic            pop,
  output logic                 q_valid,
  output logic                 q_full,
  output tsvn_pkg::job_t       head
);

  tsvn_pkg::job_t slots [tsvn_pkg::QUEUE_DEPTH];
  logic [tsvn_pkg::QPTR_W-1:0] wr_ptr;
  logic [tsvn_pkg::QPTR_W-1:0] rd_ptr;
  logic [tsvn_pkg::QCNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign q_valid = (count != '0);
  assign q_full  = (count == tsvn_pkg::QCNT_W'(tsvn_pkg::QUEUE_DEPTH));
  assign head    = slots[rd_ptr];
  assign do_push = push & ~q_full;
  assign do_pop  = pop & q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == tsvn_pkg::QPTR_W'(tsvn_pkg::QUEUE_DEPTH - 1)) ? '0 :
                  wr_ptr + tsvn_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == tsvn_pkg::QPTR_W'(tsvn_pkg::QUEUE_DEPTH - 1)) ? '0 :
                  rd_ptr + tsvn_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + tsvn_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - tsvn_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

endmodule

`default_nettype wire

>>> design/tsvn_back.sv
// ----------------------------------------------------------------------------
// tsvn_back
// byte sequencer: unless the output stalls, walks the head job one output byte per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tsvn_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire tsvn_pkg::job_t  job,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           char_out,
  output logic                 last_of_run
);

  logic [tsvn_pkg::POS_W-1:0] pos;
  logic [tsvn_pkg::LEN_W-1:0] pos_l;
  logic [tsvn_pkg::LEN_W-1:0] width_l;
  logic [tsvn_pkg::LEN_W-1:0] nlen;
  logic [tsvn_pkg::LEN_W-1:0] didx;
  logic [tsvn_pkg::LEN_W-1:0] tidx;
  logic [7:0] ch;
  logic is_last;
  logic advance;

  always_comb begin
    pos_l   = tsvn_pkg::LEN_W'(pos);
    width_l = tsvn_pkg::LEN_W'(job.width);
    nlen    = job.num_en ? width_l + tsvn_pkg::LEN_W'(1) : '0;
    didx    = width_l - tsvn_pkg::LEN_W'(1) - pos_l;
    tidx    = pos_l - nlen;
    if (job.num_en && pos_l < width_l) begin
      // leading spaces pad the number to its field width
      if (didx >= tsvn_pkg::LEN_W'(job.sig)) begin
        ch = tsvn_pkg::CH_SPACE;
      end else begin
        ch = tsvn_pkg::CH_ZERO | {4'd0, job.digits[didx[tsvn_pkg::DIG_IDX_W-1:0]]};
      end
    end else if (job.num_en && pos_l == width_l) begin
      ch = tsvn_pkg::CH_TAB;
    end else begin
      ch = job.tail[tidx[tsvn_pkg::TIDX_W-1:0]];
    end
    is_last = (pos == job.len_m1);
  end

  assign advance = q_valid & (~out_valid | out_ready);
  assign q_pop   = advance & is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (advance) begin
      out_valid <= 1'b1;
      pos       <= is_last ? '0 : pos + tsvn_pkg::POS_W'(1);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      char_out    <= ch;
      last_of_run <= is_last;
    end
  end

endmodule

`default_nettype wire

>>> design/tsvn_checker.sv
// ----------------------------------------------------------------------------
// tsvn_checker
// port-level checks of the text stream visualizer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tsvn_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [7:0]                      char_out,
  input wire logic                            last_of_run
);

  // output register empties on reset
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled output transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(last_of_run))
    else $error("stalled output changed");

  // a raw newline only ever closes a run
  a_nl_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_out == tsvn_pkg::CH_NL |-> last_of_run)
    else $error("newline not last of run");

  // a full queue means the back has a byte on offer
  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with nothing to send");

endmodule

bind text_stream_visualizer_numberer tsvn_checker u_tsvn_checker (.*);

`default_nettype wire
